[rtl/csb_pkg.sv]
// ----------------------------------------------------------------------------
// csb_pkg: shared types for the cursor sequence buffer
// Command and status codes, the shift operation broadcast to the cell row,
// and the flag group the controller hands to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_ADVANCE = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_ATTACH  = 3'd3,
		CMD_REMOVE  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_ITEM = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} shift_op_t;

	typedef struct packed {
		logic    take_value;
		logic    has_item;
		status_t status;
	} ctrl_flags_t;

endpackage

`default_nettype wire

[rtl/csb_cell.sv]
// ----------------------------------------------------------------------------
// csb_cell: one entry of the sequence
// Holds, loads the new value, or takes its left or right neighbor's entry
// depending on the broadcast shift operation and its own position.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_cell #(
	parameter int INDEX       = 0,
	parameter int IDX_W       = 5,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                       clk,
	input  wire csb_pkg::shift_op_t   op,
	input  wire [IDX_W-1:0]           pos,
	input  wire [VALUE_WIDTH-1:0]     value,
	input  wire [VALUE_WIDTH-1:0]     left_data,
	input  wire [VALUE_WIDTH-1:0]     right_data,
	output logic [VALUE_WIDTH-1:0]    data_q
);
	import csb_pkg::*;

	localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

	logic [VALUE_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (op)
			OP_INSERT: begin
				if (MyIdx == pos) begin
					data_d = value;
				end else if (MyIdx > pos) begin
					data_d = left_data;
				end
			end
			OP_REMOVE: begin
				// close the gap: everything from the cursor on moves one place down
				if (MyIdx >= pos) begin
					data_d = right_data;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

`default_nettype wire

[rtl/csb_ctrl.sv]
// ----------------------------------------------------------------------------
// csb_ctrl: cursor and fill count control
// Decodes a command against the cursor and fill count, drives the shift
// operation for the cell row and picks where the new current value comes from.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_ctrl #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5,
	parameter int CNT_W = 6
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          accept,
	input  wire [2:0]                    cmd,
	output csb_pkg::shift_op_t           op,
	output logic [IDX_W-1:0]             pos,
	output logic [IDX_W-1:0]             rd_idx,
	output logic [CNT_W-1:0]             count_next,
	output csb_pkg::ctrl_flags_t         flags
);
	import csb_pkg::*;

	logic [CNT_W-1:0] cursor_q, fill_q;
	logic [CNT_W-1:0] cursor_d, fill_d;
	logic [CNT_W-1:0] cursor_inc;
	logic             has_cur, full;
	shift_op_t        op_d;
	status_t          status_d;
	logic             take_d;
	logic [CNT_W-1:0] rd_full;

	assign has_cur    = cursor_q < fill_q;
	assign full       = fill_q >= CNT_W'(DEPTH);
	assign cursor_inc = cursor_q + CNT_W'(1);

	always_comb begin
		cursor_d = cursor_q;
		fill_d   = fill_q;
		op_d     = OP_HOLD;
		pos      = cursor_q[IDX_W-1:0];
		status_d = ST_OK;
		take_d   = 1'b0;
		rd_full  = cursor_q;
		case (cmd_t'(cmd))
			CMD_START: begin
				if (fill_q != '0) begin
					cursor_d = '0;
					rd_full  = '0;
				end
			end
			CMD_ADVANCE: begin
				if (has_cur) begin
					cursor_d = cursor_inc;
					rd_full  = cursor_inc;
				end else begin
					status_d = ST_NO_ITEM;
				end
			end
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cursor_d = has_cur ? cursor_q : '0;
					pos      = cursor_d[IDX_W-1:0];
					fill_d   = fill_q + CNT_W'(1);
					op_d     = OP_INSERT;
					take_d   = 1'b1;
				end
			end
			CMD_ATTACH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					// no current item: append at the end
					cursor_d = has_cur ? cursor_inc : fill_q;
					pos      = cursor_d[IDX_W-1:0];
					fill_d   = fill_q + CNT_W'(1);
					op_d     = OP_INSERT;
					take_d   = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (has_cur) begin
					fill_d  = fill_q - CNT_W'(1);
					op_d    = OP_REMOVE;
					rd_full = cursor_inc;
				end else begin
					status_d = ST_NO_ITEM;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// rd_idx may wrap past the last cell only when no item remains current
	assign rd_idx         = rd_full[IDX_W-1:0];
	assign count_next     = fill_d;
	assign op             = accept ? op_d : OP_HOLD;
	assign flags.take_value = take_d;
	assign flags.has_item   = cursor_d < fill_d;
	assign flags.status     = status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			fill_q   <= '0;
		end else if (accept) begin
			cursor_q <= cursor_d;
			fill_q   <= fill_d;
		end
	end

endmodule

`default_nettype wire

[rtl/cursor_sequence_buffer.sv]
// ----------------------------------------------------------------------------
// cursor_sequence_buffer: ordered store of values with a cursor
// A row of entry cells shifts in parallel to open or close a slot at the
// cursor; a controller tracks cursor and fill count, and a result register
// holds the answer to each command.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   input     in_valid / in_ready    cmd, value
//   output    out_valid / out_ready  current_value, has_item, count, status
//
// One command per cycle unless the output stalls: every cell shifts in the
// cycle the item is accepted, and the result is registered at the same edge.
// A new item is taken while the held result is being taken in the same cycle.
// Output stalls hold the result and deassert in_ready until it is taken.
// Reset clears cursor, fill count and the result valid; entries need no clear.
//
`default_nettype none

module cursor_sequence_buffer #(
	parameter int DEPTH       = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [2:0]                        cmd,
	input  wire [VALUE_WIDTH-1:0]            value,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [VALUE_WIDTH-1:0]           current_value,
	output logic                             has_item,
	output logic [$clog2(DEPTH+1)-1:0]       count,
	output logic [1:0]                       status
);
	import csb_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	logic                   accept;
	shift_op_t              op;
	logic [IDX_W-1:0]       pos, rd_idx;
	logic [CNT_W-1:0]       count_next;
	ctrl_flags_t            flags;
	logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
	logic [VALUE_WIDTH-1:0] cur_d;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] cur_q;
	logic                   has_q;
	logic [CNT_W-1:0]       count_q;
	status_t                status_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	csb_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (cmd),
		.op         (op),
		.pos        (pos),
		.rd_idx     (rd_idx),
		.count_next (count_next),
		.flags      (flags)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_d, right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end
		csb_cell #(
			.INDEX       (i),
			.IDX_W       (IDX_W),
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (pos),
			.value      (value),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[i])
		);
	end

	// new current value comes from the old row or straight from the item, or is zero when no item is current
	always_comb begin
		if (!flags.has_item) begin
			cur_d = '0;
		end else if (flags.take_value) begin
			cur_d = value;
		end else begin
			cur_d = cell_data[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q    <= cur_d;
			has_q    <= flags.has_item;
			count_q  <= count_next;
			status_q <= flags.status;
		end
	end

	assign out_valid     = out_valid_q;
	assign current_value = cur_q;
	assign has_item      = has_q;
	assign count         = count_q;
	assign status        = status_q;

endmodule

`default_nettype wire
